// File: rtl/jpdt_pkg.sv
// Shared types, register indexes and constants for the joint PD torque unit.
package jpdt_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_ABAD_STOP     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HIP_STOP      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SS_STIFFNESS  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SS_DAMPING    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FULL_LIMITS   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_REDUCED_LIMIT = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DISABLED_LIM  = 3'd6;

  localparam logic [63:0] STOP_LIMITS_RESET = 64'h7FFF_FFFF_8000_0000;

  localparam logic [1:0] JOINT_ABAD = 2'd0;
  localparam logic [1:0] JOINT_HIP  = 2'd1;
  localparam logic [1:0] JOINT_KNEE = 2'd2;
  localparam logic [1:0] JOINT_NONE = 2'd3;

  localparam int unsigned FLAG_ENABLE  = 0;
  localparam int unsigned FLAG_REDUCED = 1;

  typedef struct packed {
    logic [63:0] abad_stop;
    logic [63:0] hip_stop;
    logic [30:0] ss_stiffness;
    logic [30:0] ss_damping;
    logic [47:0] full_limits;
    logic [47:0] reduced_limits;
    logic [47:0] disabled_limits;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0]  joint;
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] target_position;
    logic [31:0] target_velocity;
    logic [31:0] stiffness_gain;
    logic [31:0] damping_gain;
    logic [31:0] feedforward_torque;
    logic [1:0]  mode_flags;
  } sample_t;

  typedef struct packed {
    logic [31:0] gain_a;
    logic [32:0] err_a;
    logic [31:0] gain_b;
    logic [32:0] err_b;
    logic        sub_b;
    logic [31:0] ff;
    logic [15:0] lim;
    logic        null_joint;
  } operands_t;

  typedef struct packed {
    logic [64:0] prod_a;
    logic [64:0] prod_b;
    logic        sub_b;
    logic [31:0] ff;
    logic [15:0] lim;
    logic        null_joint;
  } products_t;

  typedef struct packed {
    logic [50:0] tau;
    logic [15:0] lim;
    logic        null_joint;
  } sum_t;

endpackage

// File: rtl/joint_pd_torque_with_soft_stops_unit.sv
// Joint PD torque controller with soft stops, four-stage pipeline: window
// test, multiply, sum, clamp. One joint sample is accepted per clock unless
// back-pressure stalls it. Each stage has its own valid bit and stalls only
// when the stage after it is full, so a held output does not block upstream
// bubbles. Configuration writes are always accepted and must be made while
// the pipeline is empty.
module joint_pd_torque_with_soft_stops_unit
  import jpdt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // position, velocity, target_position, target_velocity,
  // stiffness_gain, damping_gain, feedforward_torque
  input  logic [223:0]       s_tdata,
  // joint, mode_flags
  input  logic [3:0]         s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // torque
  output logic [31:0]        m_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  cfg_regs_t regs;
  sample_t   sample;
  operands_t ops;
  products_t prods;
  sum_t      sums;
  logic      ops_valid;
  logic      ops_ready;
  logic      prods_valid;
  logic      prods_ready;
  logic      sums_valid;
  logic      sums_ready;

  assign sample.joint              = s_tuser[1:0];
  assign sample.mode_flags         = s_tuser[3:2];
  assign sample.position           = s_tdata[31:0];
  assign sample.velocity           = s_tdata[63:32];
  assign sample.target_position    = s_tdata[95:64];
  assign sample.target_velocity    = s_tdata[127:96];
  assign sample.stiffness_gain     = s_tdata[159:128];
  assign sample.damping_gain       = s_tdata[191:160];
  assign sample.feedforward_torque = s_tdata[223:192];

  jpdt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  jpdt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (sample),
    .out_valid (ops_valid),
    .out_ready (ops_ready),
    .out_data  (ops)
  );

  jpdt_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ops_valid),
    .in_ready  (ops_ready),
    .in_data   (ops),
    .out_valid (prods_valid),
    .out_ready (prods_ready),
    .out_data  (prods)
  );

  jpdt_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prods_valid),
    .in_ready  (prods_ready),
    .in_data   (prods),
    .out_valid (sums_valid),
    .out_ready (sums_ready),
    .out_data  (sums)
  );

  jpdt_clamp u_clamp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sums_valid),
    .in_ready  (sums_ready),
    .in_data   (sums),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .torque    (m_tdata)
  );

`ifndef SYNTHESIS
  // input only backs up once every stage holds a transaction
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (ops_valid && prods_valid && sums_valid && m_tvalid))
    else $error("input stalled with a bubble in the pipeline");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ops_valid)
    else $error("accepted transaction lost at stage 1");

  a_no_output_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid straight after reset");
`endif

endmodule

// File: rtl/jpdt_cfg.sv
// Configuration register file for the joint PD torque unit.
module jpdt_cfg
  import jpdt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data,
  output cfg_regs_t          regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.abad_stop       <= STOP_LIMITS_RESET;
      regs.hip_stop        <= STOP_LIMITS_RESET;
      regs.ss_stiffness    <= '0;
      regs.ss_damping      <= '0;
      regs.full_limits     <= '0;
      regs.reduced_limits  <= '0;
      regs.disabled_limits <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ABAD_STOP:     regs.abad_stop       <= cfg_data;
        REG_HIP_STOP:      regs.hip_stop        <= cfg_data;
        REG_SS_STIFFNESS:  regs.ss_stiffness    <= cfg_data[30:0];
        REG_SS_DAMPING:    regs.ss_damping      <= cfg_data[30:0];
        REG_FULL_LIMITS:   regs.full_limits     <= cfg_data[47:0];
        REG_REDUCED_LIMIT: regs.reduced_limits  <= cfg_data[47:0];
        REG_DISABLED_LIM:  regs.disabled_limits <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/jpdt_front.sv
// Stage 1: soft-stop window test, error terms, gain and limit selection.
module jpdt_front
  import jpdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t regs,
  input  logic      in_valid,
  output logic      in_ready,
  input  sample_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output operands_t out_data
);

  logic [63:0]        window;
  logic signed [31:0] upper;
  logic signed [31:0] lower;
  logic signed [31:0] pos;
  logic               above;
  logic               below;
  logic               stopped;
  logic signed [32:0] d_up;
  logic signed [32:0] d_lo;
  logic signed [32:0] d_tgt;
  logic signed [32:0] d_vel;
  logic [47:0]        lim_table;
  operands_t          ops_next;

  assign window = (in_data.joint == JOINT_ABAD) ? regs.abad_stop : regs.hip_stop;
  assign upper  = $signed(window[63:32]);
  assign lower  = $signed(window[31:0]);
  assign pos    = $signed(in_data.position);
  assign above  = pos > upper;
  assign below  = pos < lower;
  assign stopped = ((in_data.joint == JOINT_ABAD) || (in_data.joint == JOINT_HIP))
                   && (above || below);

  assign d_up  = $signed({upper[31], upper}) - $signed({pos[31], pos});
  assign d_lo  = $signed({lower[31], lower}) - $signed({pos[31], pos});
  assign d_tgt = $signed({in_data.target_position[31], in_data.target_position})
               - $signed({pos[31], pos});
  assign d_vel = $signed({in_data.target_velocity[31], in_data.target_velocity})
               - $signed({in_data.velocity[31], in_data.velocity});

  always_comb begin
    if (!in_data.mode_flags[FLAG_ENABLE]) begin
      lim_table = regs.disabled_limits;
    end else if (in_data.mode_flags[FLAG_REDUCED]) begin
      lim_table = regs.reduced_limits;
    end else begin
      lim_table = regs.full_limits;
    end
  end

  always_comb begin
    ops_next            = '0;
    ops_next.sub_b      = stopped;
    ops_next.ff         = in_data.feedforward_torque;
    ops_next.null_joint = (in_data.joint == JOINT_NONE);
    if (stopped) begin
      ops_next.gain_a = {1'b0, regs.ss_stiffness};
      ops_next.err_a  = above ? d_up : d_lo;
      ops_next.gain_b = {1'b0, regs.ss_damping};
      ops_next.err_b  = {in_data.velocity[31], in_data.velocity};
    end else begin
      ops_next.gain_a = in_data.stiffness_gain;
      ops_next.err_a  = d_tgt;
      ops_next.gain_b = in_data.damping_gain;
      ops_next.err_b  = d_vel;
    end
    case (in_data.joint)
      JOINT_ABAD: ops_next.lim = lim_table[15:0];
      JOINT_HIP:  ops_next.lim = lim_table[31:16];
      JOINT_KNEE: ops_next.lim = lim_table[47:32];
      default:    ops_next.lim = '0;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= ops_next;
    end
  end

endmodule

// File: rtl/jpdt_mul.sv
// Stage 2: the two signed gain products.
module jpdt_mul
  import jpdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  operands_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output products_t out_data
);

  logic signed [64:0] prod_a;
  logic signed [64:0] prod_b;

  assign prod_a = $signed({{33{in_data.gain_a[31]}}, in_data.gain_a})
                * $signed({{32{in_data.err_a[32]}}, in_data.err_a});
  assign prod_b = $signed({{33{in_data.gain_b[31]}}, in_data.gain_b})
                * $signed({{32{in_data.err_b[32]}}, in_data.err_b});

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.prod_a     <= prod_a;
      out_data.prod_b     <= prod_b;
      out_data.sub_b      <= in_data.sub_b;
      out_data.ff         <= in_data.ff;
      out_data.lim        <= in_data.lim;
      out_data.null_joint <= in_data.null_joint;
    end
  end

endmodule

// File: rtl/jpdt_sum.sv
// Stage 3: scale the products down by 16 bits (floor) and add feedforward.
module jpdt_sum
  import jpdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  products_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output sum_t      out_data
);

  logic signed [50:0] term_a;
  logic signed [50:0] term_b;
  logic signed [50:0] term_b_s;
  logic signed [50:0] ff_ext;
  logic signed [50:0] tau;

  assign term_a   = $signed({{2{in_data.prod_a[64]}}, in_data.prod_a[64:16]});
  assign term_b   = $signed({{2{in_data.prod_b[64]}}, in_data.prod_b[64:16]});
  assign term_b_s = in_data.sub_b ? -term_b : term_b;
  assign ff_ext   = $signed({{19{in_data.ff[31]}}, in_data.ff});
  assign tau      = term_a + term_b_s + ff_ext;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.tau        <= tau;
      out_data.lim        <= in_data.lim;
      out_data.null_joint <= in_data.null_joint;
    end
  end

endmodule

// File: rtl/jpdt_clamp.sv
// Stage 4: clamp to the selected torque limit; holds the output register.
module jpdt_clamp
  import jpdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sum_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] torque
);

  logic signed [50:0] lim_pos;
  logic signed [50:0] lim_neg;
  logic signed [50:0] tau;
  logic [31:0]        torque_next;

  assign lim_pos = $signed({27'd0, in_data.lim, 8'd0});
  assign lim_neg = -lim_pos;
  assign tau     = $signed(in_data.tau);

  always_comb begin
    if (in_data.null_joint) begin
      torque_next = '0;
    end else if (tau > lim_pos) begin
      torque_next = lim_pos[31:0];
    end else if (tau < lim_neg) begin
      torque_next = lim_neg[31:0];
    end else begin
      torque_next = tau[31:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      torque <= torque_next;
    end
  end

endmodule

// File: tb/joint_pd_torque_with_soft_stops_unit_tb.sv
// Self-checking testbench for the joint PD torque unit with soft stops.
module joint_pd_torque_with_soft_stops_unit_tb;
  import jpdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE = 3'd7;
  localparam logic [1:0] MODE_OFF = 2'b00;
  localparam logic [1:0] MODE_FULL = 2'b01;
  localparam logic [1:0] MODE_OFF_REDUCED = 2'b10;
  localparam logic [1:0] MODE_REDUCED = 2'b11;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct {
    sample_t     smp;
    bit          typed;
    logic [31:0] torque;
  } stim_row_t;

  typedef struct {
    int          seq;
    logic [31:0] torque;
  } torque_exp_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [223:0]       s_tdata;
  logic [3:0]         s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [31:0]        m_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [63:0]        cfg_data;

  // local copy of the register file
  logic [63:0] abad_window;
  logic [63:0] hip_window;
  logic [30:0] stop_kp;
  logic [30:0] stop_kd;
  logic [47:0] full_lims;
  logic [47:0] reduced_lims;
  logic [47:0] disabled_lims;

  torque_exp_t torque_q[$];
  torque_exp_t got_exp;
  stim_row_t   directed_rows[$];
  int          mismatches;
  int          sent;
  int          received;
  int unsigned cycles;
  int unsigned gap_pct;
  int unsigned stall_pct;
  bit          calm;

  joint_pd_torque_with_soft_stops_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] predict_torque(sample_t s);
    longint      pos;
    longint      vel;
    longint      kp;
    longint      kd;
    longint      ff;
    longint      upper;
    longint      lower;
    longint      stop_at;
    longint      tau;
    longint      lim;
    logic [63:0] window;
    logic [47:0] lim_set;
    bit          stopped;
    pos = $signed(s.position);
    vel = $signed(s.velocity);
    kp = $signed(s.stiffness_gain);
    kd = $signed(s.damping_gain);
    ff = $signed(s.feedforward_torque);
    stopped = 1'b0;
    stop_at = 0;
    if (s.joint == JOINT_NONE) return 32'd0;
    if (s.joint == JOINT_ABAD || s.joint == JOINT_HIP) begin
      window = (s.joint == JOINT_ABAD) ? abad_window : hip_window;
      upper = $signed(window[63:32]);
      lower = $signed(window[31:0]);
      // upper test first, so an inverted window always stops at upper when above it
      if (pos > upper) begin
        stopped = 1'b1;
        stop_at = upper;
      end else if (pos < lower) begin
        stopped = 1'b1;
        stop_at = lower;
      end
    end
    if (stopped) begin
      tau = ((longint'(stop_kp) * (stop_at - pos)) >>> 16)
          - ((longint'(stop_kd) * vel) >>> 16) + ff;
    end else begin
      tau = ((kp * (longint'($signed(s.target_position)) - pos)) >>> 16)
          + ((kd * (longint'($signed(s.target_velocity)) - vel)) >>> 16) + ff;
    end
    if (s.mode_flags[FLAG_ENABLE]) begin
      lim_set = s.mode_flags[FLAG_REDUCED] ? reduced_lims : full_lims;
    end else begin
      lim_set = disabled_lims;
    end
    lim = longint'({40'd0, lim_set[s.joint*16 +: 16], 8'd0});
    if (tau > lim) tau = lim;
    if (tau < -lim) tau = -lim;
    return tau[31:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic idle_sender(int unsigned n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // lower valid and hold off until every outstanding torque has been returned
  task automatic drain_pipeline();
    idle_sender(1);
    while (torque_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(sample_t smp, bit typed, logic [31:0] torque);
    torque_exp_t e;
    if (!calm && $urandom_range(99) < gap_pct) idle_sender($urandom_range(1, 14));
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {smp.feedforward_torque, smp.damping_gain, smp.stiffness_gain,
                smp.target_velocity, smp.target_position, smp.velocity, smp.position};
    s_tuser <= {smp.mode_flags, smp.joint};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    e.seq = sent;
    e.torque = typed ? torque : predict_torque(smp);
    torque_q.push_back(e);
    sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ABAD_STOP:     abad_window = value;
      REG_HIP_STOP:      hip_window = value;
      REG_SS_STIFFNESS:  stop_kp = value[30:0];
      REG_SS_DAMPING:    stop_kd = value[30:0];
      REG_FULL_LIMITS:   full_lims = value[47:0];
      REG_REDUCED_LIMIT: reduced_lims = value[47:0];
      REG_DISABLED_LIM:  disabled_lims = value[47:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(logic [63:0] abad, logic [63:0] hip, logic [63:0] kps,
                             logic [63:0] kds, logic [63:0] full, logic [63:0] reduced,
                             logic [63:0] disabled);
    write_reg(REG_ABAD_STOP, abad);
    write_reg(REG_HIP_STOP, hip);
    write_reg(REG_SS_STIFFNESS, kps);
    write_reg(REG_SS_DAMPING, kds);
    write_reg(REG_FULL_LIMITS, full);
    write_reg(REG_REDUCED_LIMIT, reduced);
    write_reg(CFG_IDX_SPARE, {$urandom, $urandom});
    write_reg(REG_DISABLED_LIM, disabled);
  endtask

  task automatic add_row(logic [1:0] joint, logic [31:0] pos, logic [31:0] vel,
                         logic [31:0] tpos, logic [31:0] tvel, logic [31:0] kp,
                         logic [31:0] kd, logic [31:0] ff, logic [1:0] mode,
                         bit typed, logic [31:0] torque);
    stim_row_t r;
    r.smp.joint = joint;
    r.smp.position = pos;
    r.smp.velocity = vel;
    r.smp.target_position = tpos;
    r.smp.target_velocity = tvel;
    r.smp.stiffness_gain = kp;
    r.smp.damping_gain = kd;
    r.smp.feedforward_torque = ff;
    r.smp.mode_flags = mode;
    r.typed = typed;
    r.torque = torque;
    directed_rows.push_back(r);
  endtask

  function automatic logic [31:0] rand_q16();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return {{12{r[19]}}, r[19:0]};
      1: return {{14{r[17]}}, r[17:0]};
      2: begin
        case (r[1:0])
          2'd0: return Q_MAX;
          2'd1: return Q_MIN;
          2'd2: return 32'd0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return r;
    endcase
  endfunction

  function automatic logic [63:0] rand_window();
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom_range(0, 32'h0004_0000);
    b = -$urandom_range(0, 32'h0004_0000);
    case ($urandom_range(0, 4))
      0, 1: return {a, b};
      2: return {b, a};
      3: return {$urandom, $urandom};
      default: return {Q_MAX, b};
    endcase
  endfunction

  function automatic logic [63:0] rand_gain();
    if ($urandom_range(0, 2) != 0) return 64'($urandom_range(0, 32'h0004_0000));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_limits();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return r;
      1: return 64'h0000_FFFF_FFFF_FFFF;
      default: return {16'd0, 4'd0, r[43:32], 4'd0, r[27:16], 4'd0, r[11:0]};
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.joint = ($urandom_range(0, 9) == 0) ? JOINT_NONE : 2'($urandom_range(0, 2));
    s.position = rand_q16();
    s.velocity = rand_q16();
    s.target_position = rand_q16();
    s.target_velocity = rand_q16();
    s.stiffness_gain = rand_q16();
    s.damping_gain = rand_q16();
    s.feedforward_torque = rand_q16();
    s.mode_flags = 2'($urandom_range(0, 3));
    return s;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("joint_pd_torque_with_soft_stops_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (torque_q.size() == 0) begin
        report_mismatch($sformatf("unexpected torque %h", m_tdata));
      end else begin
        got_exp = torque_q.pop_front();
        if (m_tdata !== got_exp.torque)
          report_mismatch($sformatf("item %0d torque %h, expected %h",
                                    got_exp.seq, m_tdata, got_exp.torque));
      end
      received++;
    end
  end

  // result-side back-pressure
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned p;
    int unsigned i;
    int unsigned pass;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ABAD_STOP;
    cfg_data = '0;
    abad_window = STOP_LIMITS_RESET;
    hip_window = STOP_LIMITS_RESET;
    stop_kp = '0;
    stop_kd = '0;
    full_lims = '0;
    reduced_lims = '0;
    disabled_lims = '0;
    mismatches = 0;
    sent = 0;
    received = 0;
    cycles = 0;
    gap_pct = 25;
    stall_pct = 25;
    calm = 1'b0;

    // typed torques hold for the directed register set loaded below
    add_row(JOINT_KNEE, 0, 0, 0, 0, 0, 0, Q_MAX, MODE_FULL, 1, 32'h00FF_FF00);
    add_row(JOINT_KNEE, 0, 0, 0, 0, 0, 0, Q_MIN, MODE_FULL, 1, 32'hFF00_0100);
    add_row(JOINT_KNEE, 0, 0, 0, 0, 0, 0, Q_MAX, MODE_REDUCED, 1, 32'h0001_0000);
    add_row(JOINT_KNEE, 0, 0, 0, 0, 0, 0, Q_MAX, MODE_OFF, 1, 32'd0);
    add_row(JOINT_KNEE, 0, 0, 0, 0, 0, 0, Q_MAX, MODE_OFF_REDUCED, 1, 32'd0);
    add_row(JOINT_NONE, '1, '1, '1, '1, '1, '1, '1, MODE_FULL, 1, 32'd0);
    add_row(JOINT_NONE, 0, 0, 0, 0, 0, 0, 0, MODE_REDUCED, 1, 32'd0);
    add_row(JOINT_ABAD, 32'h0002_0000, 32'h0000_8000, 0, 0, 32'h0001_0000, 0, 0,
            MODE_FULL, 0, 0);
    add_row(JOINT_ABAD, 32'hFFFE_0000, 32'hFFFF_8000, 0, 0, 0, 0, 32'h0000_4000,
            MODE_FULL, 0, 0);
    add_row(JOINT_ABAD, 32'h0000_8000, 32'h0000_1000, 32'h0000_4000, 0, 32'h0003_0000,
            32'h0001_0000, 0, MODE_FULL, 0, 0);
    add_row(JOINT_ABAD, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, MODE_FULL, 0, 0);
    add_row(JOINT_ABAD, 32'hFFFF_0000, 0, 0, 0, 32'h0001_0000, 0, 0, MODE_FULL, 0, 0);
    add_row(JOINT_HIP, 0, 32'h0000_2000, 0, 0, 0, 0, 0, MODE_FULL, 0, 0);
    add_row(JOINT_HIP, 32'hFFFD_0000, 0, 0, 0, 0, 0, 0, MODE_FULL, 0, 0);
    add_row(JOINT_HIP, Q_MAX, Q_MIN, 0, 0, 0, 0, 0, MODE_FULL, 0, 0);
    add_row(JOINT_KNEE, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, MODE_FULL, 0, 0);
    add_row(JOINT_KNEE, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, MODE_REDUCED, 0, 0);
    add_row(JOINT_ABAD, Q_MAX, Q_MIN, 0, 0, 0, 0, Q_MIN, MODE_FULL, 0, 0);
    add_row(JOINT_ABAD, Q_MIN, Q_MAX, 0, 0, 0, 0, 0, MODE_FULL, 0, 0);
    add_row(JOINT_KNEE, 0, 0, 0, 0, 0, 0, 0, MODE_FULL, 0, 0);
    add_row(JOINT_KNEE, 32'h0000_8000, 0, 32'h0001_0000, 32'h0000_4000, 32'h0002_0000,
            32'h0004_0000, 32'h0000_2000, MODE_FULL, 0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // two walks: reset registers (every torque limit is zero), then the directed set
    for (pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        drain_pipeline();
        load_config({32'h0001_0000, 32'hFFFF_0000}, {32'hFFFF_0000, 32'h0001_0000},
                    64'h0002_0000, 64'h0000_8000, 64'hFFFF_FFFF_FFFF,
                    64'h0100_0100_0100, 64'd0);
      end
      foreach (directed_rows[i]) begin
        send_sample(directed_rows[i].smp, pass == 0 || directed_rows[i].typed,
                    (pass == 0) ? 32'd0 : directed_rows[i].torque);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      drain_pipeline();
      case (p)
        0: load_config('1, '0, '1, '1, '1, '1, '1);
        1: load_config({Q_MIN, Q_MAX}, STOP_LIMITS_RESET, '0, 64'h7FFF_FFFF, '0,
                       64'hFFFF_FFFF_FFFF, rand_limits());
        default: load_config(rand_window(), rand_window(), rand_gain(), rand_gain(),
                             rand_limits(), rand_limits(), rand_limits());
      endcase
      calm = (p == PHASES - 1);
      gap_pct = (p == 2) ? 0 : $urandom_range(5, 60);
      stall_pct = (p == 2) ? 0 : $urandom_range(5, 60);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (!calm && $urandom_range(0, 199) == 0) drain_pipeline();
        send_sample(rand_sample(), 0, 0);
      end
    end

    drain_pipeline();
    repeat (20) @(posedge clk);
    if (torque_q.size() != 0)
      report_mismatch($sformatf("%0d torques never returned", torque_q.size()));
    if (mismatches == 0) begin
      $display("joint_pd_torque_with_soft_stops_unit verification clean");
    end else begin
      $display("joint_pd_torque_with_soft_stops_unit verification failed");
    end
    $finish;
  end

endmodule
